>>> sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // Item kinds as carried on the input channel
  typedef enum logic [2:0] {
    KIND_TICK         = 3'd0,
    KIND_NEW          = 3'd1,
    KIND_DELETE       = 3'd2,
    KIND_SET_ENABLE   = 3'd3,
    KIND_SET_INTERVAL = 3'd4
  } kind_e;

  // Operations after classification by the front end
  typedef enum logic [2:0] {
    OP_TICK,
    OP_NEW,
    OP_DELETE,
    OP_SET_ENABLE,
    OP_SET_INTERVAL,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    RES_EXPIRY   = 1'b0,
    RES_COMPLETE = 1'b1
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_HIT,
    ST_SELECT,
    ST_EMIT,
    ST_LOOKUP,
    ST_COMPLETE
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic [30:0] period_ms;
    logic        enable_flag;
    logic [31:0] now_ms;
  } ptb_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] result_id;
    logic [1:0]  status;
    logic        last;
  } ptb_out_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] timer_id;
    logic [30:0] period_ms;
    logic        enable_flag;
    logic [31:0] now_ms;
  } ptb_cmd_t;

  // Queue status toward the back end
  typedef struct packed {
    logic     valid;
    ptb_cmd_t cmd;
  } ptb_q_out_t;

endpackage

>>> sv/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timers with create, delete, enable, re-time and tick.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   ptb_in_t  (one item)
// out      output     out_valid_o / out_stall_i ptb_out_t (one result)
//
// New, delete, set enable, set interval: the command is loaded, the slots are
// searched one by one, and the completion is emitted. A tick is loaded, a
// pass marks the due timers, each expiry takes a lowest-id search and an
// emit, a last search finds none, and the completion follows. Reset empties
// the bank at once; no clearing pass. A two-entry command queue lets input
// be taken while the engine or a stalled output holds.
// ----------------------------------------------------------------------------
module periodic_timer_bank import ptb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ptb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ptb_out_t out_data_o
);

  ptb_q_out_t head;
  logic       pop;

  ptb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  ptb_engine #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/ptb_fifo.sv
// ----------------------------------------------------------------------------
// ptb_fifo
// Two-entry command queue between the front end and the timer engine.
// ----------------------------------------------------------------------------
module ptb_fifo import ptb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ptb_cmd_t   push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output ptb_q_out_t head_o
);

  ptb_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> sv/ptb_front.sv
// ----------------------------------------------------------------------------
// ptb_front
// Accepts input transactions, classifies the kind and queues a command.
// ----------------------------------------------------------------------------
module ptb_front import ptb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ptb_in_t    in_data_i,
  input  logic       pop_i,
  output ptb_q_out_t head_o
);

  ptb_cmd_t cmd;
  logic     full;
  logic     push;

  assign in_stall_o = full;
  assign push       = in_valid_i & ~full;

  // Map the raw kind onto an operation; unused kinds become a no-op
  always_comb begin
    cmd.timer_id    = in_data_i.timer_id;
    cmd.period_ms   = in_data_i.period_ms;
    cmd.enable_flag = in_data_i.enable_flag;
    cmd.now_ms      = in_data_i.now_ms;
    case (in_data_i.kind)
      KIND_TICK:         cmd.op = OP_TICK;
      KIND_NEW:          cmd.op = OP_NEW;
      KIND_DELETE:       cmd.op = OP_DELETE;
      KIND_SET_ENABLE:   cmd.op = OP_SET_ENABLE;
      KIND_SET_INTERVAL: cmd.op = OP_SET_INTERVAL;
      default:           cmd.op = OP_NOP;
    endcase
  end

  ptb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (pop_i),
    .head_o      (head_o)
  );

endmodule

>>> sv/ptb_engine.sv
// ----------------------------------------------------------------------------
// ptb_engine
// Timer slot storage and sequencer: scans slots for ticks and lookups,
// emits results through an output register.
// ----------------------------------------------------------------------------
module ptb_engine import ptb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ptb_q_out_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ptb_out_t   out_data_o
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  // Slot storage
  logic        slot_valid_q    [NUM_TIMERS];
  logic [31:0] slot_id_q       [NUM_TIMERS];
  logic [30:0] slot_interval_q [NUM_TIMERS];
  logic        slot_enable_q   [NUM_TIMERS];
  logic [31:0] slot_start_q    [NUM_TIMERS];
  logic        hit_q           [NUM_TIMERS];

  logic [31:0] id_counter_q, last_tick_q;

  state_e      state_q, state_d;
  ptb_cmd_t    cmd_q;
  logic [IW-1:0] idx_q, idx_d, best_q, best_d;
  logic [31:0] best_id_q, best_id_d;
  logic        found_q, found_d;
  logic [31:0] res_id_q, res_id_d;
  status_e     status_q, status_d;

  logic        out_valid_q;
  ptb_out_t    out_q, out_d;
  logic        out_load;
  logic        out_free;

  // Per-cycle strobes
  logic        load_cmd;
  logic        hit_wr, hit_val;
  logic        expire;
  logic        slot_act;
  logic        tick_done;
  logic [31:0] due;
  logic        is_idx_last;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o       = load_cmd;
  assign is_idx_last = (idx_q == LAST_IDX);
  assign due         = slot_start_q[idx_q] + {1'b0, slot_interval_q[idx_q]};

  // Sequencer next state and strobes
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    best_d    = best_q;
    best_id_d = best_id_q;
    found_d   = found_q;
    res_id_d  = res_id_q;
    status_d  = status_q;
    load_cmd  = 1'b0;
    hit_wr    = 1'b0;
    hit_val   = 1'b0;
    expire    = 1'b0;
    slot_act  = 1'b0;
    tick_done = 1'b0;
    out_load  = 1'b0;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          load_cmd = 1'b1;
          idx_d    = '0;
          res_id_d = '0;
          status_d = STATUS_OK;
          case (head_i.cmd.op)
            OP_TICK:         state_d = ST_SCAN_HIT;
            OP_NEW,
            OP_DELETE,
            OP_SET_ENABLE,
            OP_SET_INTERVAL: state_d = ST_LOOKUP;
            default:         state_d = ST_COMPLETE;
          endcase
        end
      end
      // Mark every slot that is due at this tick
      ST_SCAN_HIT: begin
        hit_wr  = 1'b1;
        hit_val = slot_valid_q[idx_q] & slot_enable_q[idx_q] & (due < cmd_q.now_ms);
        idx_d   = idx_q + 1'b1;
        if (is_idx_last) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_SELECT;
        end
      end
      // Find the marked slot with the lowest id, lowest slot on ties
      ST_SELECT: begin
        if (hit_q[idx_q] && (!found_q || slot_id_q[idx_q] < best_id_q)) begin
          found_d   = 1'b1;
          best_d    = idx_q;
          best_id_d = slot_id_q[idx_q];
        end
        idx_d = idx_q + 1'b1;
        if (is_idx_last) begin
          idx_d   = '0;
          state_d = found_d ? ST_EMIT : ST_COMPLETE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          expire            = 1'b1;
          out_load          = 1'b1;
          out_d.result_kind = RES_EXPIRY;
          out_d.result_id   = best_id_q;
          out_d.status      = STATUS_OK;
          out_d.last        = 1'b0;
          found_d           = 1'b0;
          state_d           = ST_SELECT;
        end
      end
      // Search for a free slot (new) or the addressed id
      ST_LOOKUP: begin
        if ((cmd_q.op == OP_NEW) ? !slot_valid_q[idx_q]
            : (slot_valid_q[idx_q] && slot_id_q[idx_q] == cmd_q.timer_id)) begin
          slot_act = 1'b1;
          if (cmd_q.op == OP_NEW) res_id_d = id_counter_q + 32'd1;
          state_d = ST_COMPLETE;
        end else begin
          idx_d = idx_q + 1'b1;
          if (is_idx_last) begin
            status_d = (cmd_q.op == OP_NEW) ? STATUS_FULL : STATUS_NOT_FOUND;
            state_d  = ST_COMPLETE;
          end
        end
      end
      ST_COMPLETE: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = RES_COMPLETE;
          out_d.result_id   = res_id_q;
          out_d.status      = status_q;
          out_d.last        = 1'b1;
          tick_done         = (cmd_q.op == OP_TICK);
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      id_counter_q <= '0;
      last_tick_q  <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) slot_valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (tick_done) last_tick_q <= cmd_q.now_ms;
      if (slot_act) begin
        case (cmd_q.op)
          OP_NEW: begin
            slot_valid_q[idx_q] <= 1'b1;
            id_counter_q        <= id_counter_q + 32'd1;
          end
          OP_DELETE: slot_valid_q[idx_q] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    best_q    <= best_d;
    best_id_q <= best_id_d;
    found_q   <= found_d;
    res_id_q  <= res_id_d;
    status_q  <= status_d;
    if (load_cmd) cmd_q <= head_i.cmd;
    if (out_load) out_q <= out_d;
    if (hit_wr) hit_q[idx_q] <= hit_val;
    if (expire) begin
      hit_q[best_q]        <= 1'b0;
      slot_start_q[best_q] <= cmd_q.now_ms;
    end
    if (slot_act) begin
      case (cmd_q.op)
        OP_NEW: begin
          slot_id_q[idx_q]       <= id_counter_q + 32'd1;
          slot_interval_q[idx_q] <= cmd_q.period_ms;
          slot_enable_q[idx_q]   <= cmd_q.enable_flag;
          slot_start_q[idx_q]    <= last_tick_q;
        end
        OP_SET_ENABLE:   slot_enable_q[idx_q]   <= cmd_q.enable_flag;
        OP_SET_INTERVAL: slot_interval_q[idx_q] <= cmd_q.period_ms;
        default: ;
      endcase
    end
  end

endmodule
